>>> hdl/icy_md_pkg.sv
// ----------------------------------------------------------------------------
// icy_md_pkg
// Shared types, constants and the title prefix table for the ICY metadata
// demultiplexer.
// ----------------------------------------------------------------------------
package icy_md_pkg;

	localparam int TITLE_MAX_DEF = 121;
	localparam int MI_W          = 20;
	localparam int ML_W          = 12;
	localparam int MP_W          = 4;
	localparam int TC_W          = 7;
	localparam int META_SHIFT    = 4;
	localparam int PREFIX_LEN    = 13;
	localparam int RES_DEPTH     = 4;
	localparam int RES_PTR_W     = $clog2(RES_DEPTH);
	localparam int RES_CNT_W     = $clog2(RES_DEPTH + 1);

	localparam logic [7:0] QUOTE_CHAR = 8'h27;

	typedef enum logic [1:0] {
		KIND_AUDIO = 2'd0,
		KIND_TITLE = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	typedef enum logic {
		PH_AUDIO = 1'b0,
		PH_META  = 1'b1
	} phase_t;

	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      kind;
		logic       last;
	} result_t;

	// Results of one input word: n valid slots, r0 first.
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} step_t;

	typedef struct packed {
		logic [RES_CNT_W-1:0] count;
		logic                 room2;
	} resq_stat_t;

	// Characters of StreamTitle=' by position.
	function automatic logic [7:0] prefix_char(input logic [MP_W-1:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0:    c = "S";
			4'd1:    c = "t";
			4'd2:    c = "r";
			4'd3:    c = "e";
			4'd4:    c = "a";
			4'd5:    c = "m";
			4'd6:    c = "T";
			4'd7:    c = "i";
			4'd8:    c = "t";
			4'd9:    c = "l";
			4'd10:   c = "e";
			4'd11:   c = "=";
			4'd12:   c = QUOTE_CHAR;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

>>> hdl/icy_md_core.sv
// ----------------------------------------------------------------------------
// icy_md_core
// Stream state and title matcher: turns one stored word into up to two
// results and advances the counters.
// ----------------------------------------------------------------------------
module icy_md_core #(
	parameter int TITLE_MAX = icy_md_pkg::TITLE_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [icy_md_pkg::MI_W-1:0] cfg_wdata,
	input  logic                       step,
	input  logic [7:0]                 data_s1,
	output icy_md_pkg::step_t          res
);

	localparam logic [icy_md_pkg::TC_W-1:0] TMAX = icy_md_pkg::TC_W'(TITLE_MAX);
	localparam logic [icy_md_pkg::MP_W-1:0] PFX_FULL =
		icy_md_pkg::MP_W'(icy_md_pkg::PREFIX_LEN);

	logic [icy_md_pkg::MI_W-1:0] meta_interval_q;
	icy_md_pkg::phase_t          phase_q, phase_n;
	logic [icy_md_pkg::MI_W-1:0] audio_left_q, audio_left_n;
	logic [icy_md_pkg::ML_W-1:0] meta_left_q, meta_left_n;
	logic [icy_md_pkg::MP_W-1:0] match_pos_q, match_pos_n;
	logic                        title_active_q, title_active_n;
	logic                        title_found_q, title_found_n;
	logic [icy_md_pkg::TC_W-1:0] title_count_q, title_count_n;

	logic emit_audio, emit_char, emit_close, emit_blk_end;

	// Next state and emit decisions
	always_comb begin
		phase_n        = phase_q;
		audio_left_n   = audio_left_q;
		meta_left_n    = meta_left_q;
		match_pos_n    = match_pos_q;
		title_active_n = title_active_q;
		title_found_n  = title_found_q;
		title_count_n  = title_count_q;
		emit_audio     = 1'b0;
		emit_char      = 1'b0;
		emit_close     = 1'b0;
		emit_blk_end   = 1'b0;

		if (meta_interval_q == '0) begin
			emit_audio = 1'b1;
		end else if (phase_q == icy_md_pkg::PH_AUDIO) begin
			if (audio_left_q != '0) begin
				audio_left_n = audio_left_q - 1'b1;
				emit_audio   = 1'b1;
			end else if (data_s1 == 8'h00) begin
				audio_left_n = meta_interval_q;
			end else begin
				meta_left_n    = {data_s1, {icy_md_pkg::META_SHIFT{1'b0}}};
				phase_n        = icy_md_pkg::PH_META;
				match_pos_n    = '0;
				title_active_n = 1'b0;
				title_found_n  = 1'b0;
				title_count_n  = '0;
			end
		end else begin
			if (title_active_q) begin
				if (data_s1 == icy_md_pkg::QUOTE_CHAR) begin
					emit_close     = 1'b1;
					title_active_n = 1'b0;
					title_found_n  = 1'b1;
				end else if (title_count_q < TMAX) begin
					emit_char     = 1'b1;
					title_count_n = title_count_q + 1'b1;
				end
			end else if (!title_found_q) begin
				if (match_pos_q >= PFX_FULL) begin
					if (data_s1 != icy_md_pkg::QUOTE_CHAR) begin
						title_active_n = 1'b1;
						title_count_n  = icy_md_pkg::TC_W'(1);
						emit_char      = 1'b1;
					end
					match_pos_n = '0;
				end else if (data_s1 == icy_md_pkg::prefix_char(match_pos_q)) begin
					match_pos_n = match_pos_q + 1'b1;
				end else if (data_s1 == icy_md_pkg::prefix_char('0)) begin
					match_pos_n = icy_md_pkg::MP_W'(1);
				end else begin
					match_pos_n = '0;
				end
			end

			meta_left_n = (meta_left_q != '0) ? meta_left_q - 1'b1 : meta_left_q;
			if (meta_left_n == '0) begin
				if (title_active_n) begin
					emit_blk_end   = 1'b1;
					title_active_n = 1'b0;
					title_found_n  = 1'b1;
				end
				phase_n      = icy_md_pkg::PH_AUDIO;
				audio_left_n = meta_interval_q;
				match_pos_n  = '0;
			end
		end
	end

	// Result slots
	always_comb begin
		res.r0 = '{out_byte: data_s1, kind: icy_md_pkg::KIND_AUDIO, last: 1'b1};
		res.r1 = '{out_byte: 8'h00, kind: icy_md_pkg::KIND_END, last: 1'b1};
		res.n  = 2'd0;
		if (emit_audio) begin
			res.n = 2'd1;
		end else if (emit_char) begin
			res.r0.kind = icy_md_pkg::KIND_TITLE;
			if (emit_blk_end) begin
				res.r0.last = 1'b0;
				res.n       = 2'd2;
			end else begin
				res.n = 2'd1;
			end
		end else if (emit_close || emit_blk_end) begin
			res.r0 = '{out_byte: 8'h00, kind: icy_md_pkg::KIND_END, last: 1'b1};
			res.n  = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_interval_q <= '0;
			phase_q         <= icy_md_pkg::PH_AUDIO;
			audio_left_q    <= '0;
			meta_left_q     <= '0;
			match_pos_q     <= '0;
			title_active_q  <= 1'b0;
			title_found_q   <= 1'b0;
			title_count_q   <= '0;
		end else if (cfg_we) begin
			meta_interval_q <= cfg_wdata;
			phase_q         <= icy_md_pkg::PH_AUDIO;
			audio_left_q    <= cfg_wdata;
			meta_left_q     <= '0;
			match_pos_q     <= '0;
			title_active_q  <= 1'b0;
			title_found_q   <= 1'b0;
			title_count_q   <= '0;
		end else if (step) begin
			phase_q        <= phase_n;
			audio_left_q   <= audio_left_n;
			meta_left_q    <= meta_left_n;
			match_pos_q    <= match_pos_n;
			title_active_q <= title_active_n;
			title_found_q  <= title_found_n;
			title_count_q  <= title_count_n;
		end
	end

endmodule

>>> hdl/icy_md_resq.sv
// ----------------------------------------------------------------------------
// icy_md_resq
// Result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module icy_md_resq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  icy_md_pkg::step_t      wr,
	input  logic                   pop,
	output icy_md_pkg::result_t    head,
	output logic                   nonempty,
	output icy_md_pkg::resq_stat_t stat
);

	// Pointers wrap naturally: depth is a power of two.
	icy_md_pkg::result_t                mem_q [icy_md_pkg::RES_DEPTH];
	logic [icy_md_pkg::RES_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [icy_md_pkg::RES_CNT_W-1:0]   cnt_q;
	logic [icy_md_pkg::RES_CNT_W-1:0]   n_in;
	logic [icy_md_pkg::RES_PTR_W-1:0]   wr_ptr1;

	assign n_in     = push ? icy_md_pkg::RES_CNT_W'(wr.n) : '0;
	assign wr_ptr1  = wr_ptr_q + 1'b1;
	assign head     = mem_q[rd_ptr_q];
	assign nonempty = (cnt_q != '0);
	assign stat.count = cnt_q;
	assign stat.room2 = (cnt_q <= icy_md_pkg::RES_CNT_W'(icy_md_pkg::RES_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push && wr.n != 2'd0) begin
			mem_q[wr_ptr_q] <= wr.r0;
		end
		if (push && wr.n == 2'd2) begin
			mem_q[wr_ptr1] <= wr.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + icy_md_pkg::RES_PTR_W'(n_in);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + n_in - icy_md_pkg::RES_CNT_W'(pop);
		end
	end

endmodule

>>> hdl/icy_metadata_demux.sv
// ----------------------------------------------------------------------------
// icy_metadata_demux
// Splits an ICY stream into audio bytes and stream title characters.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | role
//  ---------+-------------------------------------------+---------------------
//  input    | in_valid, in_stall, data_byte             | stream byte in
//  output   | out_valid, out_stall, out_byte, kind,     | audio byte, title
//           | last_of_run                               | char or title end
//  config   | cfg_we, cfg_wdata                         | meta_interval write
//
// One input word per cycle while in_stall is low. An accepted word waits in
// the input register until it unloads, is decoded there and drops its
// results into a four-entry result queue. A word that yields two results
// (last title character plus the end marker at the block end) needs two
// output handshakes; the queue absorbs the extra one. in_stall rises only
// while the stored word cannot unload, which is when the queue lacks room
// for two results. Reset clears all counters and the matcher; meta_interval
// resets to zero, which passes every byte as audio.
// ----------------------------------------------------------------------------
module icy_metadata_demux #(
	parameter int TITLE_MAX = icy_md_pkg::TITLE_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  data_byte,
	input  logic                        cfg_we,
	input  logic [icy_md_pkg::MI_W-1:0] cfg_wdata,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  out_byte,
	output logic [1:0]                  kind,
	output logic                        last_of_run
);

	logic                   valid_s1;
	logic [7:0]             data_s1;
	logic                   advance;
	logic                   in_take;
	logic                   pop;
	icy_md_pkg::step_t      res;
	icy_md_pkg::result_t    head;
	icy_md_pkg::resq_stat_t stat;

	// Unload the stored word when the queue can take both possible results.
	assign advance  = valid_s1 && stat.room2;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;
	assign pop      = out_valid && !out_stall;

	// Input register: load on accept, drop when the word is decoded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1 <= data_byte;
		end
	end

	// Decode against the stream state; state advances with the word.
	icy_md_core #(
		.TITLE_MAX(TITLE_MAX)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.step     (advance),
		.data_s1  (data_s1),
		.res      (res)
	);

	// Hold results until the consumer takes them, one per handshake.
	icy_md_resq u_resq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (advance),
		.wr      (res),
		.pop     (pop),
		.head    (head),
		.nonempty(out_valid),
		.stat    (stat)
	);

	assign out_byte    = head.out_byte;
	assign kind        = head.kind;
	assign last_of_run = head.last;

	// Checks

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= icy_md_pkg::RES_CNT_W'(icy_md_pkg::RES_DEPTH))
		else $error("result queue overfilled");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 &&
			stat.count > icy_md_pkg::RES_CNT_W'(icy_md_pkg::RES_DEPTH - 2)))
		else $error("input stalled with queue room");

	a_pair_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.n == 2'd2) |->
			(res.r0.kind == icy_md_pkg::KIND_TITLE && !res.r0.last &&
			 res.r1.kind == icy_md_pkg::KIND_END && res.r1.last))
		else $error("two results not a title char followed by end marker");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.n != 2'd0) |-> (res.n != 2'd3 && (res.n == 2'd2 || res.r0.last)))
		else $error("bad result count or missing last marker");

endmodule
